FILE: rtl/core/prrts_pkg.sv
`timescale 1ns / 1ps

package prrts_pkg;

   // table geometry
   localparam int TASK_SLOTS = 8;
   localparam int IDX_W      = 3;   // task index width
   localparam int CNT_W      = 4;   // task count width, holds TASK_SLOTS itself
   localparam int PRIO_W     = 4;
   localparam int TICK_W     = 32;
   localparam int CMD_W      = 3;
   localparam int STS_W      = 2;

   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TASK_SLOTS);

   // command codes
   localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELAY  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd4;

   // result status codes
   localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
   localparam logic [STS_W-1:0] STS_FULL    = 2'd1;
   localparam logic [STS_W-1:0] STS_IGNORED = 2'd2;

   typedef enum logic [1:0] {
      TS_READY   = 2'd0,
      TS_RUNNING = 2'd1,
      TS_BLOCKED = 2'd2
   } task_state_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_EXEC,
      CS_SCAN,
      CS_PICK,
      CS_KEEP,
      CS_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_EXEC,
      OP_SCAN,
      OP_PICK,
      OP_KEEP,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      logic do_pick;    // current command runs a selection
      logic scan_last;  // this step visits the last created task
      logic hit;        // pick step found the winning task
      logic out_free;   // result register can take a new beat
   } dp_status_type;

endpackage

FILE: rtl/core/prrts_ctrl.sv
`timescale 1ns / 1ps

module prrts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  prrts_pkg::dp_status_type dp_status,
   output prrts_pkg::dp_op_type     dp_op
);

   prrts_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prrts_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prrts_pkg::CS_IDLE: begin
            if (req_valid) state_in = prrts_pkg::CS_EXEC;
         end
         prrts_pkg::CS_EXEC: begin
            state_in = dp_status.do_pick ? prrts_pkg::CS_SCAN : prrts_pkg::CS_DONE;
         end
         prrts_pkg::CS_SCAN: begin
            if (dp_status.scan_last) state_in = prrts_pkg::CS_PICK;
         end
         prrts_pkg::CS_PICK: begin
            if (dp_status.hit) state_in = prrts_pkg::CS_DONE;
            else if (dp_status.scan_last) state_in = prrts_pkg::CS_KEEP;
         end
         prrts_pkg::CS_KEEP: begin
            state_in = prrts_pkg::CS_DONE;
         end
         prrts_pkg::CS_DONE: begin
            if (dp_status.out_free) state_in = prrts_pkg::CS_IDLE;
         end
         default: begin
            state_in = prrts_pkg::CS_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      dp_op     = prrts_pkg::OP_NOP;
      case (state_ff)
         prrts_pkg::CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) dp_op = prrts_pkg::OP_LOAD;
         end
         prrts_pkg::CS_EXEC: dp_op = prrts_pkg::OP_EXEC;
         prrts_pkg::CS_SCAN: dp_op = prrts_pkg::OP_SCAN;
         prrts_pkg::CS_PICK: dp_op = prrts_pkg::OP_PICK;
         prrts_pkg::CS_KEEP: dp_op = prrts_pkg::OP_KEEP;
         prrts_pkg::CS_DONE: begin
            if (dp_status.out_free) dp_op = prrts_pkg::OP_PUBLISH;
         end
         default: dp_op = prrts_pkg::OP_NOP;
      endcase
   end

endmodule

FILE: rtl/core/prrts_dp.sv
`timescale 1ns / 1ps

module prrts_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [prrts_pkg::CMD_W-1:0]           req_command,
   input  logic [prrts_pkg::PRIO_W-1:0]          req_task_priority_in,
   input  logic [prrts_pkg::TICK_W-1:0]          req_delay_ticks,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [prrts_pkg::IDX_W-1:0]           rsp_running_task,
   output logic [prrts_pkg::STS_W-1:0]           rsp_status,
   output logic [prrts_pkg::TICK_W-1:0]          rsp_tick_now,
   output logic [prrts_pkg::CNT_W-1:0]           rsp_tasks_created,
   input  prrts_pkg::dp_op_type                  dp_op,
   output prrts_pkg::dp_status_type              dp_status
);

   localparam int N = prrts_pkg::TASK_SLOTS;

   // latched command
   logic [prrts_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [prrts_pkg::PRIO_W-1:0] prio_arg_ff, prio_arg_in;
   logic [prrts_pkg::TICK_W-1:0] dly_ff, dly_in;

   // task table
   prrts_pkg::task_state_type    task_state_ff [N];
   prrts_pkg::task_state_type    task_state_in [N];
   logic [prrts_pkg::PRIO_W-1:0] task_prio_ff [N];
   logic [prrts_pkg::PRIO_W-1:0] task_prio_in [N];
   logic [prrts_pkg::TICK_W-1:0] wake_at_ff [N];
   logic [prrts_pkg::TICK_W-1:0] wake_at_in [N];

   // scheduler state
   logic [prrts_pkg::CNT_W-1:0]  total_ff, total_in;
   logic [prrts_pkg::IDX_W-1:0]  cur_ff, cur_in;
   logic [prrts_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic                         started_ff, started_in;

   // scan working registers
   logic [prrts_pkg::IDX_W-1:0]  cnt_ff, cnt_in;
   logic [prrts_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [prrts_pkg::PRIO_W-1:0] best_ff, best_in;
   logic [prrts_pkg::STS_W-1:0]  sts_ff, sts_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [prrts_pkg::IDX_W-1:0]  rsp_task_ff, rsp_task_in;
   logic [prrts_pkg::STS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [prrts_pkg::TICK_W-1:0] rsp_tick_ff, rsp_tick_in;
   logic [prrts_pkg::CNT_W-1:0]  rsp_total_ff, rsp_total_in;

   // single table read port
   logic [prrts_pkg::IDX_W-1:0]  rd_idx;
   prrts_pkg::task_state_type    rd_state;
   logic [prrts_pkg::PRIO_W-1:0] rd_prio;
   logic [prrts_pkg::TICK_W-1:0] rd_wake;

   logic [prrts_pkg::CNT_W-1:0]  last_cnt;
   logic                         scan_last, cur_last, idx_last, hit, do_pick;
   logic                         wake_hit, demote;
   prrts_pkg::task_state_type    scan_state;

   assign rd_idx   = (dp_op == prrts_pkg::OP_PICK) ? idx_ff : cnt_ff;
   assign rd_state = task_state_ff[rd_idx];
   assign rd_prio  = task_prio_ff[rd_idx];
   assign rd_wake  = wake_at_ff[rd_idx];

   assign last_cnt  = total_ff - prrts_pkg::CNT_W'(1);
   assign scan_last = ({1'b0, cnt_ff} == last_cnt);
   assign cur_last  = ({1'b0, cur_ff} == last_cnt);
   assign idx_last  = ({1'b0, idx_ff} == last_cnt);
   assign hit       = (rd_state == prrts_pkg::TS_READY) && (rd_prio == best_ff);

   // a blocked task wakes on tick once its nonzero wake time is reached;
   // the running current task drops back to ready for the selection
   assign wake_hit = (cmd_ff == prrts_pkg::CMD_TICK) && (rd_state == prrts_pkg::TS_BLOCKED) &&
                     (rd_wake != '0) && (tick_ff >= rd_wake);
   assign demote   = (rd_idx == cur_ff) && (rd_state == prrts_pkg::TS_RUNNING);
   assign scan_state = (wake_hit || demote) ? prrts_pkg::TS_READY : rd_state;

   always_comb begin
      do_pick = 1'b0;
      case (cmd_ff)
         prrts_pkg::CMD_START: do_pick = (total_ff != '0) && !started_ff;
         prrts_pkg::CMD_TICK:  do_pick = started_ff;
         prrts_pkg::CMD_DELAY: do_pick = started_ff && (total_ff != '0) &&
                                         ({1'b0, cur_ff} < total_ff);
         prrts_pkg::CMD_YIELD: do_pick = started_ff && (total_ff != '0);
         default:              do_pick = 1'b0;
      endcase
   end

   assign dp_status.do_pick   = do_pick;
   assign dp_status.scan_last = scan_last;
   assign dp_status.hit       = hit;
   assign dp_status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd_in        = cmd_ff;
      prio_arg_in   = prio_arg_ff;
      dly_in        = dly_ff;
      task_state_in = task_state_ff;
      task_prio_in  = task_prio_ff;
      wake_at_in    = wake_at_ff;
      total_in      = total_ff;
      cur_in        = cur_ff;
      tick_in       = tick_ff;
      started_in    = started_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      sts_in        = sts_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;
      rsp_tick_in   = rsp_tick_ff;
      rsp_total_in  = rsp_total_ff;

      case (dp_op)
         prrts_pkg::OP_LOAD: begin
            cmd_in      = req_command;
            prio_arg_in = req_task_priority_in;
            dly_in      = req_delay_ticks;
         end
         prrts_pkg::OP_EXEC: begin
            cnt_in  = '0;
            best_in = '0;
            sts_in  = prrts_pkg::STS_DONE;
            case (cmd_ff)
               prrts_pkg::CMD_CREATE: begin
                  if (total_ff >= prrts_pkg::SLOTS_CNT) begin
                     sts_in = prrts_pkg::STS_FULL;
                  end else begin
                     task_state_in[total_ff[prrts_pkg::IDX_W-1:0]] = prrts_pkg::TS_READY;
                     task_prio_in[total_ff[prrts_pkg::IDX_W-1:0]]  = prio_arg_ff;
                     wake_at_in[total_ff[prrts_pkg::IDX_W-1:0]]    = '0;
                     total_in = total_ff + prrts_pkg::CNT_W'(1);
                  end
               end
               prrts_pkg::CMD_START: begin
                  if (total_ff == '0) begin
                     sts_in = prrts_pkg::STS_IGNORED;
                  end else if (!started_ff) begin
                     started_in       = 1'b1;
                     task_state_in[0] = prrts_pkg::TS_RUNNING;
                     cur_in           = '0;
                  end
               end
               prrts_pkg::CMD_TICK: begin
                  tick_in = tick_ff + prrts_pkg::TICK_W'(1);
                  if (!started_ff) sts_in = prrts_pkg::STS_IGNORED;
               end
               prrts_pkg::CMD_DELAY: begin
                  if (!do_pick) begin
                     sts_in = prrts_pkg::STS_IGNORED;
                  end else begin
                     wake_at_in[cur_ff]    = tick_ff + dly_ff;
                     task_state_in[cur_ff] = prrts_pkg::TS_BLOCKED;
                  end
               end
               prrts_pkg::CMD_YIELD: begin
                  if (!do_pick) sts_in = prrts_pkg::STS_IGNORED;
               end
               default: begin
                  sts_in = prrts_pkg::STS_IGNORED;
               end
            endcase
         end
         prrts_pkg::OP_SCAN: begin
            task_state_in[rd_idx] = scan_state;
            if (wake_hit) wake_at_in[rd_idx] = '0;
            if ((scan_state == prrts_pkg::TS_READY) && (rd_prio > best_ff)) best_in = rd_prio;
            if (scan_last) begin
               cnt_in = '0;
               idx_in = cur_last ? '0 : cur_ff + prrts_pkg::IDX_W'(1);
            end else begin
               cnt_in = cnt_ff + prrts_pkg::IDX_W'(1);
            end
         end
         prrts_pkg::OP_PICK: begin
            if (hit) begin
               task_state_in[idx_ff] = prrts_pkg::TS_RUNNING;
               cur_in                = idx_ff;
            end else begin
               idx_in = idx_last ? '0 : idx_ff + prrts_pkg::IDX_W'(1);
               cnt_in = cnt_ff + prrts_pkg::IDX_W'(1);
            end
         end
         prrts_pkg::OP_KEEP: begin
            task_state_in[cur_ff] = prrts_pkg::TS_RUNNING;
         end
         prrts_pkg::OP_PUBLISH: begin
            rsp_valid_in  = 1'b1;
            rsp_task_in   = cur_ff;
            rsp_status_in = sts_ff;
            rsp_tick_in   = tick_ff;
            rsp_total_in  = total_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_state_ff <= '{default: prrts_pkg::TS_READY};
         total_ff      <= '0;
         cur_ff        <= '0;
         tick_ff       <= '0;
         started_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         task_state_ff <= task_state_in;
         total_ff      <= total_in;
         cur_ff        <= cur_in;
         tick_ff       <= tick_in;
         started_ff    <= started_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      prio_arg_ff   <= prio_arg_in;
      dly_ff        <= dly_in;
      task_prio_ff  <= task_prio_in;
      wake_at_ff    <= wake_at_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      sts_ff        <= sts_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tick_ff   <= rsp_tick_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_running_task  = rsp_task_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_tick_now      = rsp_tick_ff;
   assign rsp_tasks_created = rsp_total_ff;

endmodule

FILE: rtl/core/priority_round_robin_task_scheduler.sv
// Priority round-robin task scheduler. Each request beat carries one command
// (create, start, tick, delay, yield) and yields exactly one response beat with
// the current task index, a status code, the tick count and the number of tasks
// created. Up to eight tasks live in a table of state, priority and wake time.
// A command is worked on one at a time: a command that runs no selection goes
// from acceptance through its execute step straight to its response beat; tick
// after start, delay, yield and the first start run a selection as two passes
// over the N created tasks of the table through its single read port -
// one full pass that wakes, demotes and finds the highest ready priority, one
// round-robin pass that stops at the winner, or visits all N slots and keeps the
// current task when no task is ready. The response register lets the next
// request beat be taken while a finished response still waits for rsp_ready.
`timescale 1ns / 1ps

module priority_round_robin_task_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [prrts_pkg::CMD_W-1:0]        req_command,
   input  logic [prrts_pkg::PRIO_W-1:0]       req_task_priority_in,
   input  logic [prrts_pkg::TICK_W-1:0]       req_delay_ticks,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [prrts_pkg::IDX_W-1:0]        rsp_running_task,
   output logic [prrts_pkg::STS_W-1:0]        rsp_status,
   output logic [prrts_pkg::TICK_W-1:0]       rsp_tick_now,
   output logic [prrts_pkg::CNT_W-1:0]        rsp_tasks_created
);

   prrts_pkg::dp_op_type     dp_op;
   prrts_pkg::dp_status_type dp_status;

   // sequencer: accept, execute, scan, pick, keep, publish
   prrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_op     (dp_op)
   );

   // task table, tick counter and response register
   prrts_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_command          (req_command),
      .req_task_priority_in (req_task_priority_in),
      .req_delay_ticks      (req_delay_ticks),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_running_task     (rsp_running_task),
      .rsp_status           (rsp_status),
      .rsp_tick_now         (rsp_tick_now),
      .rsp_tasks_created    (rsp_tasks_created),
      .dp_op                (dp_op),
      .dp_status            (dp_status)
   );

   // a published beat never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (dp_op == prrts_pkg::OP_PUBLISH) |-> (!rsp_valid || rsp_ready))
      else $error("response overwritten while pending");

   // the current task always lies inside the created range
   a_task_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_tasks_created != '0)) |->
         ({1'b0, rsp_running_task} < rsp_tasks_created))
      else $error("running task beyond created tasks");

   // table full is reported only with all slots taken
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == prrts_pkg::STS_FULL)) |->
         (rsp_tasks_created == prrts_pkg::SLOTS_CNT))
      else $error("full status with free slots");

   // a request beat is taken only when the sequencer is idle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");

endmodule

FILE: verif/priority_round_robin_task_scheduler_tb.sv
`timescale 1ns / 1ps

module priority_round_robin_task_scheduler_tb;
   import prrts_pkg::*;

   // command codes outside the defined set, handled as ignored
   localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

   localparam int RANDOM_BEATS = 1800;
   localparam int CALM_FROM    = 800;    // no idling on either side in this beat window
   localparam int CALM_TO      = 1100;
   localparam int STALL_LIMIT  = 4000;   // cycles without any accepted beat
   localparam int TAIL_CYCLES  = 40;

   typedef struct {
      logic [CMD_W-1:0]  command;
      logic [PRIO_W-1:0] prio;
      logic [TICK_W-1:0] delay;
      bit                wait_drain;   // hold this beat until every result is back
   } sched_cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]  running;
      logic [STS_W-1:0]  status;
      logic [TICK_W-1:0] tick;
      logic [CNT_W-1:0]  created;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid            = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command          = '0;
   logic [PRIO_W-1:0]   req_task_priority_in = '0;
   logic [TICK_W-1:0]   req_delay_ticks      = '0;
   logic                rsp_valid;
   logic                rsp_ready            = 1'b0;
   logic [IDX_W-1:0]    rsp_running_task;
   logic [STS_W-1:0]    rsp_status;
   logic [TICK_W-1:0]   rsp_tick_now;
   logic [CNT_W-1:0]    rsp_tasks_created;

   priority_round_robin_task_scheduler uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_task_priority_in (req_task_priority_in),
      .req_delay_ticks      (req_delay_ticks),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_running_task     (rsp_running_task),
      .rsp_status           (rsp_status),
      .rsp_tick_now         (rsp_tick_now),
      .rsp_tasks_created    (rsp_tasks_created)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Scheduler shadow: task table and counters as the block should hold them
   // ---------------------------------------------------------------------
   task_state_type     sched_state [TASK_SLOTS] = '{default: TS_READY};
   logic [PRIO_W-1:0]  sched_prio  [TASK_SLOTS] = '{default: '0};
   logic [TICK_W-1:0]  sched_wake  [TASK_SLOTS] = '{default: '0};
   logic [CNT_W-1:0]   sched_total   = '0;
   logic [IDX_W-1:0]   sched_cur     = '0;
   logic [TICK_W-1:0]  sched_tick    = '0;
   bit                 sched_started = 1'b0;

   // coverage tallies for the summary
   int n_create, n_tick, n_delay, n_yield, n_other;
   int n_full, n_ignored, n_no_ready;

   // Demote the running task, then pick the first task at the top ready
   // priority, scanning round-robin from the slot after the current one.
   function automatic void sched_select();
      logic [PRIO_W-1:0] top;
      int                idx;
      if (sched_total == 0 || CNT_W'(sched_cur) >= sched_total)
         return;
      if (sched_state[sched_cur] == TS_RUNNING)
         sched_state[sched_cur] = TS_READY;
      top = '0;
      for (int i = 0; i < int'(sched_total); i++)
         if (sched_state[i] == TS_READY && sched_prio[i] > top)
            top = sched_prio[i];
      for (int i = 0; i < int'(sched_total); i++) begin
         idx = (int'(sched_cur) + 1 + i) % int'(sched_total);
         if (sched_state[idx] == TS_READY && sched_prio[idx] == top) begin
            sched_state[idx] = TS_RUNNING;
            sched_cur = IDX_W'(idx);
            return;
         end
      end
      // nobody ready: keep the current task, even a blocked one
      sched_state[sched_cur] = TS_RUNNING;
      n_no_ready++;
   endfunction

   function automatic sched_result_type sched_apply(logic [CMD_W-1:0] cmd,
                                                    logic [PRIO_W-1:0] prio,
                                                    logic [TICK_W-1:0] dly);
      sched_result_type res;
      logic [STS_W-1:0] sts;
      sts = STS_DONE;
      case (cmd)
         CMD_CREATE: begin
            n_create++;
            if (sched_total >= SLOTS_CNT) begin
               sts = STS_FULL;
            end else begin
               sched_state[sched_total] = TS_READY;
               sched_prio[sched_total]  = prio;
               sched_wake[sched_total]  = '0;
               sched_total++;
            end
         end
         CMD_START: begin
            n_other++;
            if (sched_total == 0) begin
               sts = STS_IGNORED;
            end else if (!sched_started) begin
               sched_started  = 1'b1;
               sched_state[0] = TS_RUNNING;
               sched_cur      = '0;
               sched_select();
            end
         end
         CMD_TICK: begin
            n_tick++;
            sched_tick++;
            if (!sched_started) begin
               sts = STS_IGNORED;
            end else begin
               for (int i = 0; i < int'(sched_total); i++)
                  if (sched_state[i] == TS_BLOCKED && sched_wake[i] != 0 &&
                      sched_tick >= sched_wake[i]) begin
                     sched_state[i] = TS_READY;
                     sched_wake[i]  = '0;
                  end
               sched_select();
            end
         end
         CMD_DELAY: begin
            n_delay++;
            if (!sched_started || sched_total == 0 || CNT_W'(sched_cur) >= sched_total) begin
               sts = STS_IGNORED;
            end else begin
               sched_wake[sched_cur]  = sched_tick + dly;
               sched_state[sched_cur] = TS_BLOCKED;
               sched_select();
            end
         end
         CMD_YIELD: begin
            n_yield++;
            if (!sched_started || sched_total == 0)
               sts = STS_IGNORED;
            else
               sched_select();
         end
         default: begin
            n_other++;
            sts = STS_IGNORED;
         end
      endcase
      if (sts == STS_FULL) n_full++;
      if (sts == STS_IGNORED) n_ignored++;
      res.running = sched_cur;
      res.status  = sts;
      res.tick    = sched_tick;
      res.created = sched_total;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus queue and driver
   // ---------------------------------------------------------------------
   sched_cmd_type     pending_cmds[$];
   sched_result_type  expected_results[$];
   logic [TICK_W-1:0] gen_ticks = '0;    // tick count the queued commands will reach
   int                random_beats = 0;
   int                beats_sent   = 0;
   int                results_seen = 0;
   int                mismatches   = 0;
   int                stall_cycles = 0;

   task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [PRIO_W-1:0] prio,
                            logic [TICK_W-1:0] dly, bit drain = 1'b0);
      sched_cmd_type c;
      c.command    = cmd;
      c.prio       = prio;
      c.delay      = dly;
      c.wait_drain = drain;
      pending_cmds.push_back(c);
      if (cmd == CMD_TICK) gen_ticks++;
      // only tick, delay and yield commands count toward the random budget
      if (cmd == CMD_TICK || cmd == CMD_DELAY || cmd == CMD_YIELD) random_beats++;
   endtask

   always @(posedge clock) begin
      sched_cmd_type nxt;
      bit taken, calm, send;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         taken = req_valid && req_ready;
         calm  = beats_sent >= CALM_FROM && beats_sent < CALM_TO;
         if (taken) beats_sent <= beats_sent + 1;
         rsp_ready <= calm || $urandom_range(99) >= 32;
         // advance only when the slot is free; otherwise hold the beat
         if (!req_valid || taken) begin
            send = pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 32);
            // drain point: hold off until every outstanding result has come back
            if (send && pending_cmds[0].wait_drain && (taken || beats_sent != results_seen))
               send = 1'b0;
            if (send) begin
               nxt = pending_cmds.pop_front();
               req_command          <= nxt.command;
               req_task_priority_in <= nxt.prio;
               req_delay_ticks      <= nxt.delay;
               req_valid            <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check result beats, predict on accepted request beats
   // ---------------------------------------------------------------------
   task automatic check_field(string field, logic [TICK_W-1:0] want, logic [TICK_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      sched_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: beat with nothing pending (task %0d, status %0d)",
                           results_seen, rsp_running_task, rsp_status);
            end else begin
               want = expected_results.pop_front();
               check_field("running_task", TICK_W'(want.running), TICK_W'(rsp_running_task));
               check_field("status", TICK_W'(want.status), TICK_W'(rsp_status));
               check_field("tick_now", want.tick, rsp_tick_now);
               check_field("tasks_created", TICK_W'(want.created), TICK_W'(rsp_tasks_created));
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(sched_apply(req_command, req_task_priority_in,
                                                   req_delay_ticks));
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("priority_round_robin_task_scheduler: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: directed commands, random mix, drain and final check
   // ---------------------------------------------------------------------
   initial begin
      int kind, len, r;

      // before start: tick counts, everything else is ignored
      queue_cmd(CMD_TICK, 4'hF, '1);
      queue_cmd(CMD_DELAY, 4'h0, '1);
      queue_cmd(CMD_YIELD, 4'h0, '0);
      queue_cmd(CMD_RSVD_HI, 4'hF, '1);
      queue_cmd(CMD_RSVD_LO, 4'h0, '0);
      queue_cmd(CMD_START, 4'h0, '0);            // no tasks yet
      queue_cmd(CMD_CREATE, 4'h0, '0);
      queue_cmd(CMD_CREATE, 4'hF, '0);
      queue_cmd(CMD_CREATE, 4'hF, '1);
      queue_cmd(CMD_START, 4'h0, '0, 1'b1);      // first start, after a drain
      queue_cmd(CMD_START, 4'h0, '0);            // repeated start is a no-op
      queue_cmd(CMD_TICK, 4'h0, '0);
      queue_cmd(CMD_YIELD, 4'h0, '0);
      queue_cmd(CMD_DELAY, 4'h0, '0);            // wake time equals the tick count
      queue_cmd(CMD_TICK, 4'h0, '0);
      queue_cmd(CMD_DELAY, 4'h0, -gen_ticks);    // wake time wraps to zero, never wakes
      queue_cmd(CMD_DELAY, 4'h0, 32'd1);
      // create after start, fill the table, then two too many
      queue_cmd(CMD_CREATE, 4'h9, '0);
      queue_cmd(CMD_CREATE, 4'hA, '0);
      queue_cmd(CMD_CREATE, 4'h5, '0);
      queue_cmd(CMD_CREATE, 4'hF, '0);
      queue_cmd(CMD_CREATE, 4'h3, '0);
      queue_cmd(CMD_CREATE, 4'hC, '0);
      queue_cmd(CMD_CREATE, 4'h6, '0);            // table full
      queue_cmd(CMD_TICK, 4'h0, '0);

      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            // ordinary traffic: ticks, short delays and yields
            len = $urandom_range(12, 4);
            repeat (len) begin
               r = $urandom_range(99);
               if (r < 45)
                  queue_cmd(CMD_TICK, PRIO_W'($urandom), $urandom);
               else if (r < 75)
                  queue_cmd(CMD_DELAY, PRIO_W'($urandom), $urandom_range(12));
               else
                  queue_cmd(CMD_YIELD, PRIO_W'($urandom), $urandom);
            end
         end else if (kind < 75) begin
            // block tasks with nine delays, then tick so that short delays wake again
            repeat (9) queue_cmd(CMD_DELAY, '0, $urandom_range(40, 1));
            len = $urandom_range(20, 5);
            repeat (len) queue_cmd(CMD_TICK, '0, '0);
         end else if (kind < 85) begin
            queue_cmd(CMD_CREATE + CMD_W'($urandom_range(7)), PRIO_W'($urandom), $urandom);
         end else if (kind < 95) begin
            if ($urandom_range(1))
               queue_cmd(CMD_DELAY, '0, -gen_ticks);
            else
               queue_cmd(CMD_DELAY, '0, $urandom);
         end else if (kind < 97) begin
            queue_cmd(CMD_YIELD, '0, '0, 1'b1);
         end else begin
            queue_cmd(CMD_CREATE, PRIO_W'($urandom), $urandom);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wait for the queue to empty and every result to come back
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_results.size() != 0 ||
             results_seen != beats_sent);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         mismatches += expected_results.size();
         $display("%0d results never arrived", expected_results.size());
      end

      $display("ran %0d commands: %0d create, %0d tick, %0d delay, %0d yield, %0d other",
               beats_sent, n_create, n_tick, n_delay, n_yield, n_other);
      $display("table full %0d times, %0d ignored, %0d picks with no ready task, final tick %0d",
               n_full, n_ignored, n_no_ready, sched_tick);
      if (mismatches == 0) begin
         $display("priority_round_robin_task_scheduler: match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("priority_round_robin_task_scheduler: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/prrts_pkg.sv
rtl/core/prrts_ctrl.sv
rtl/core/prrts_dp.sv
rtl/core/priority_round_robin_task_scheduler.sv
verif/priority_round_robin_task_scheduler_tb.sv
